// File: sv/brta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brta_pkg
// Shared widths for the balanced random tournament assigner.
// ----------------------------------------------------------------------------
package brta_pkg;

  localparam int WORD_W   = 32;
  localparam int ROUND_W  = 6;
  localparam int SEAT_W   = 3;
  localparam int PLAYER_W = 6;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [ROUND_W-1:0]  round_t;
  typedef logic [SEAT_W-1:0]   seat_t;
  typedef logic [PLAYER_W-1:0] player_t;

endpackage

// File: sv/brta_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brta_in_if / brta_out_if
// Valid/ready channels carrying the random word in and the seat result out.
// ----------------------------------------------------------------------------
interface brta_in_if;
  import brta_pkg::*;

  logic  valid;
  logic  ready;
  word_t random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface brta_out_if;
  import brta_pkg::*;

  logic    valid;
  logic    ready;
  round_t  round_number;
  seat_t   seat_number;
  player_t chosen_player;
  logic    was_forced;
  logic    round_done;
  logic    set_done;
  logic    stuck;

  modport source (
    output valid, output round_number, output seat_number, output chosen_player,
    output was_forced, output round_done, output set_done, output stuck,
    input  ready
  );
  modport sink (
    input  valid, input round_number, input seat_number, input chosen_player,
    input  was_forced, input round_done, input set_done, input stuck,
    output ready
  );
endinterface

// File: sv/brta_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brta_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module brta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/brta_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brta_mod
// Bit-serial restoring remainder: word mod divisor, one dividend bit a cycle.
// ----------------------------------------------------------------------------
module brta_mod #(
  parameter int DIV_W = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  brta_pkg::word_t    dividend,
  input  logic [DIV_W-1:0]   divisor,
  output logic               done,
  output logic [DIV_W-1:0]   rem
);
  import brta_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  word_t            dvd_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  assign trial = {rem_r, dvd_r[WORD_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        dvd_r <= dividend;
        rem_r <= '0;
      end else if (run_r) begin
        rem_r <= (trial >= {1'b0, divisor}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WORD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: sv/balanced_random_tournament_assigner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balanced_random_tournament_assigner
// Fills NUM_PLAYERS tournaments of SEATS distinct players, one seat per word.
// ----------------------------------------------------------------------------
// Each input word fills one seat and yields one result word. A seat takes a
// walk over all quotas to find a forced player and sum the pool; a forced
// pick then goes straight to the update. A weighted pick adds a bit-serial
// remainder and a second walk that stops at the chosen player. The walks are
// bounded by the single read port of the quota RAM. The input is not ready
// while a seat is in progress; a finished result waits in the output register
// while the next word is taken. An empty pool returns a stuck result and
// leaves the state as it was.
module balanced_random_tournament_assigner #(
  parameter int NUM_PLAYERS = 64,
  parameter int SEATS       = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  brta_in_if.sink       in_word,
  brta_out_if.source    out_word
);
  import brta_pkg::*;

  localparam int IW  = $clog2(NUM_PLAYERS);
  localparam int CW  = $clog2(NUM_PLAYERS + 1);
  localparam int QW  = $clog2(SEATS + 1);
  localparam int EW  = (QW > CW) ? QW : CW;
  localparam int PLW = $clog2(NUM_PLAYERS * SEATS + 1);
  localparam int SW  = (SEATS > 1) ? $clog2(SEATS) : 1;
  localparam int RW  = IW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_P1   = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_P2   = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]             state_r;
  word_t                  word_r;
  logic [CW-1:0]          rd_idx_r;
  logic                   d_vld_r;
  logic [IW-1:0]          d_idx_r;
  logic [PLW-1:0]         pool_r;
  logic [PLW-1:0]         sel_r;
  logic                   frc_r;
  logic [IW-1:0]          pick_r;
  logic [QW-1:0]          pick_q_r;
  logic [NUM_PLAYERS-1:0] members_r;
  logic [NUM_PLAYERS-1:0] qvalid_r;
  logic [RW-1:0]          round_r;
  logic [SW-1:0]          seat_r;

  logic                   res_stuck_r;
  logic                   res_rdone_r;
  logic                   res_sdone_r;
  logic [RW-1:0]          res_round_r;
  logic [SW-1:0]          res_seat_r;

  logic                   out_valid_r;
  round_t                 out_round_r;
  seat_t                  out_seat_r;
  player_t                out_player_r;
  logic                   out_forced_r;
  logic                   out_rdone_r;
  logic                   out_sdone_r;
  logic                   out_stuck_r;

  logic [QW-1:0]          ram_rdata;
  logic [QW-1:0]          q;
  logic [CW-1:0]          open_left;
  logic                   walk_end;
  logic                   mod_start;
  logic                   mod_done;
  logic [PLW-1:0]         mod_rem;
  logic                   rdone;
  logic                   sdone;
  logic                   ram_we;
  logic                   out_load;

  brta_ram #(
    .WIDTH (QW),
    .DEPTH (NUM_PLAYERS)
  ) u_quota (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick_r),
    .wdata ((pick_q_r != '0) ? pick_q_r - 1'b1 : pick_q_r),
    .raddr (rd_idx_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  brta_mod #(
    .DIV_W (PLW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (word_r),
    .divisor  (pool_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign q         = qvalid_r[d_idx_r] ? ram_rdata : QW'(SEATS);
  assign open_left = CW'(NUM_PLAYERS) - CW'(round_r);
  assign walk_end  = (rd_idx_r == CW'(NUM_PLAYERS)) && !d_vld_r;
  assign mod_start = (state_r == ST_P1) && walk_end && !frc_r && (pool_r != '0);
  assign rdone     = (seat_r == SW'(SEATS - 1));
  assign sdone     = rdone && (round_r == RW'(NUM_PLAYERS - 1));
  assign ram_we    = (state_r == ST_UPD);
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_word.ready);

  assign in_word.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      d_vld_r     <= 1'b0;
      rd_idx_r    <= '0;
      members_r   <= '0;
      qvalid_r    <= '0;
      round_r     <= '0;
      seat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end

      // read pipeline shared by both walks
      if ((state_r == ST_P1 || state_r == ST_P2) && rd_idx_r != CW'(NUM_PLAYERS)) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        d_vld_r  <= 1'b1;
        d_idx_r  <= rd_idx_r[IW-1:0];
      end else begin
        d_vld_r  <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_word.valid) begin
            word_r      <= in_word.random_word;
            res_round_r <= round_r;
            res_seat_r  <= seat_r;
            rd_idx_r    <= '0;
            pool_r      <= '0;
            frc_r       <= 1'b0;
            state_r     <= ST_P1;
          end
        end
        ST_P1: begin
          if (d_vld_r) begin
            if (!frc_r && EW'(q) == EW'(open_left)) begin
              frc_r    <= 1'b1;
              pick_r   <= d_idx_r;
              pick_q_r <= q;
            end
            if (!members_r[d_idx_r]) begin
              pool_r <= pool_r + PLW'(q);
            end
          end else if (walk_end) begin
            if (frc_r) begin
              state_r <= ST_UPD;
            end else if (pool_r == '0) begin
              res_stuck_r <= 1'b1;
              state_r     <= ST_FIN;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (mod_done) begin
            sel_r    <= mod_rem;
            rd_idx_r <= '0;
            state_r  <= ST_P2;
          end
        end
        ST_P2: begin
          if (d_vld_r) begin
            if (!members_r[d_idx_r]) begin
              if (sel_r < PLW'(q)) begin
                pick_r   <= d_idx_r;
                pick_q_r <= q;
                state_r  <= ST_UPD;
              end else begin
                sel_r <= sel_r - PLW'(q);
              end
            end
          end else if (walk_end) begin
            res_stuck_r <= 1'b1;
            state_r     <= ST_FIN;
          end
        end
        ST_UPD: begin
          res_stuck_r <= 1'b0;
          res_rdone_r <= rdone;
          res_sdone_r <= sdone;
          if (sdone) begin
            qvalid_r  <= '0;
            members_r <= '0;
            round_r   <= '0;
            seat_r    <= '0;
          end else if (rdone) begin
            qvalid_r[pick_r] <= 1'b1;
            members_r        <= '0;
            round_r          <= round_r + 1'b1;
            seat_r           <= '0;
          end else begin
            qvalid_r[pick_r]  <= 1'b1;
            members_r[pick_r] <= 1'b1;
            seat_r            <= seat_r + 1'b1;
          end
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_load) begin
            // result shows the seat this word was taken for
            out_round_r  <= ROUND_W'(res_round_r);
            out_seat_r   <= SEAT_W'(res_seat_r);
            out_stuck_r  <= res_stuck_r;
            out_player_r <= res_stuck_r ? '0 : PLAYER_W'(pick_r);
            out_forced_r <= res_stuck_r ? 1'b0 : frc_r;
            out_rdone_r  <= res_stuck_r ? 1'b0 : res_rdone_r;
            out_sdone_r  <= res_stuck_r ? 1'b0 : res_sdone_r;
            res_stuck_r  <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.round_number  = out_round_r;
  assign out_word.seat_number   = out_seat_r;
  assign out_word.chosen_player = out_player_r;
  assign out_word.was_forced    = out_forced_r;
  assign out_word.round_done    = out_rdone_r;
  assign out_word.set_done      = out_sdone_r;
  assign out_word.stuck         = out_stuck_r;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for balanced_random_tournament_assigner (64 players,
// 8 seats). A directed table opens the run: word extremes, seat and round
// wrap, and a few seats whose player follows directly from the reset quotas.
// Random words then run until at least one full set of tournaments is done
// or MAX_WORDS words are sent, so the late rounds with forced picks and the
// state reload after the last seat are reached. An internal seat predictor,
// updated on every accepted word, checks each result word field by field.
// Both channels idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb;
  import brta_pkg::*;

  localparam int NP          = 64;
  localparam int NS          = 8;
  localparam int MIN_WORDS   = 400;
  localparam int MAX_WORDS   = 1160;
  localparam int TAIL_WORDS  = 40;
  localparam int DRAIN_WAIT  = 400;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    round_t  round_number;
    seat_t   seat_number;
    player_t chosen_player;
    logic    was_forced;
    logic    round_done;
    logic    set_done;
    logic    stuck;
  } seat_res_t;

  typedef struct {
    word_t     w;
    bit        typed;
    seat_res_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  brta_in_if  in_ch ();
  brta_out_if out_ch ();

  balanced_random_tournament_assigner #(
    .NUM_PLAYERS (NP),
    .SEATS       (NS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  always #6 clk = ~clk;

  // predictor state
  int unsigned   quota [NP];
  logic [NP-1:0] members;
  int unsigned   cur_round;
  int unsigned   cur_seat;
  int unsigned   sets_done;

  seat_res_t due_seats [$];
  int        mismatches = 0;
  int        sent = 0;
  bit        calm = 1'b0;
  longint    cycles = 0;

  // results that follow directly from the reset quotas
  row_t dir_rows [12] = '{
    '{32'h0000_0000, 1'b1, '{6'd0, 3'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{32'h0000_0007, 1'b1, '{6'd0, 3'd1, 6'd1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{32'h0000_0008, 1'b1, '{6'd0, 3'd2, 6'd3, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'h8000_0000, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h0000_0000, 1'b1, '{6'd1, 3'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{32'h0000_0001, 1'b1, '{6'd1, 3'd1, 6'd1, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{32'hDEAD_BEEF, 1'b0, '0},
    '{32'h1234_5678, 1'b0, '0}
  };

  function automatic void reload_pairing();
    for (int p = 0; p < NP; p++) quota[p] = NS;
    members   = '0;
    cur_round = 0;
    cur_seat  = 0;
  endfunction

  function automatic seat_res_t place_seat(word_t w);
    seat_res_t   r;
    int unsigned open_left;
    int unsigned pool;
    int unsigned sel;
    int unsigned pick;
    bit          found;
    bit          forced;
    bit          rdone;
    bit          sdone;
    r = '0;
    r.round_number = round_t'(cur_round);
    r.seat_number  = seat_t'(cur_seat);
    open_left = NP - cur_round;
    found  = 1'b0;
    forced = 1'b0;
    pick   = 0;
    for (int p = 0; p < NP; p++) begin
      if (!found && quota[p] == open_left) begin
        pick   = p;
        found  = 1'b1;
        forced = 1'b1;
      end
    end
    if (!found) begin
      pool = 0;
      for (int p = 0; p < NP; p++) begin
        if (!members[p]) pool += quota[p];
      end
      if (pool == 0) begin
        r.stuck = 1'b1;
        return r;
      end
      sel = w % pool;
      for (int p = 0; p < NP; p++) begin
        if (!found && !members[p]) begin
          if (sel < quota[p]) begin
            pick  = p;
            found = 1'b1;
          end else begin
            sel -= quota[p];
          end
        end
      end
      if (!found) begin
        r.stuck = 1'b1;
        return r;
      end
    end
    if (quota[pick] > 0) quota[pick]--;
    members[pick] = 1'b1;
    rdone = (cur_seat + 1 >= NS);
    sdone = rdone && (cur_round + 1 >= NP);
    r.chosen_player = player_t'(pick);
    r.was_forced    = forced;
    r.round_done    = rdone;
    r.set_done      = sdone;
    if (sdone) begin
      reload_pairing();
      sets_done++;
    end else if (rdone) begin
      cur_seat  = 0;
      members   = '0;
      cur_round++;
    end else begin
      cur_seat++;
    end
    return r;
  endfunction

  task automatic send_word(input word_t w, input bit typed, input seat_res_t typed_res);
    seat_res_t pred;
    in_ch.valid       <= 1'b1;
    in_ch.random_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = place_seat(w);
    due_seats.push_back(typed ? typed_res : pred);
    sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (due_seats.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    seat_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_seats.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual round %0d seat %0d",
                 $time, out_ch.round_number, out_ch.seat_number);
        mismatches++;
      end else begin
        exp_r = due_seats.pop_front();
        compare_field("round_number", exp_r.round_number, out_ch.round_number);
        compare_field("seat_number", exp_r.seat_number, out_ch.seat_number);
        compare_field("chosen_player", exp_r.chosen_player, out_ch.chosen_player);
        compare_field("was_forced", exp_r.was_forced, out_ch.was_forced);
        compare_field("round_done", exp_r.round_done, out_ch.round_done);
        compare_field("set_done", exp_r.set_done, out_ch.set_done);
        compare_field("stuck", exp_r.stuck, out_ch.stuck);
      end
    end
  end

  // result-side stalls
  int stall_left = 0;
  int rx_mode_left = 0;
  bit rx_noisy = 1'b1;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_noisy     = ($urandom_range(0, 2) != 0);
        rx_mode_left = $urandom_range(500, 5000);
      end
      rx_mode_left--;
      if (stall_left == 0 && rx_noisy && $urandom_range(0, 39) == 0)
        stall_left = $urandom_range(1, 19);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    word_t w;
    int    bursts;
    bit    tx_noisy;
    int    tx_mode_left;
    tx_noisy     = 1'b1;
    tx_mode_left = 0;
    sets_done    = 0;
    reload_pairing();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.random_word <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if ($urandom_range(0, 2) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    end
    drain_results();

    while ((sent < MIN_WORDS || sets_done == 0) && sent < MAX_WORDS) begin
      case ($urandom_range(0, 7))
        0:       w = '0;
        1:       w = '1;
        2:       w = word_t'($urandom_range(0, 1023));
        3:       w = 32'hFFFF_FFFF - word_t'($urandom_range(0, 1023));
        default: w = $urandom();
      endcase
      if (tx_mode_left == 0) begin
        tx_noisy     = ($urandom_range(0, 2) != 0);
        tx_mode_left = $urandom_range(20, 80);
      end
      tx_mode_left--;
      if (tx_noisy && $urandom_range(0, 2) == 0) begin
        bursts = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 12) : 1;
        in_ch.valid <= 1'b0;
        repeat (bursts) repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      if ($urandom_range(0, 149) == 0) drain_results();
      send_word(w, 1'b0, '0);
    end

    calm = 1'b1;
    repeat (TAIL_WORDS) send_word($urandom(), 1'b0, '0);
    in_ch.valid <= 1'b0;

    while (due_seats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
